// ===== hw/rtl/prcd_pkg.sv =====
// Shared types, codes and constants for the PDCP receive COUNT derivation block.
`default_nettype none

package prcd_pkg;

   // Widths of the word fields.
   localparam int unsigned HdrWidth    = 24;
   localparam int unsigned LenWidth    = 16;
   localparam int unsigned SnWidth     = 18;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned CfgWidth    = 2;

   // Header layout: D/C bit on top, reserved bits, then the sequence number.
   localparam int unsigned RsvBitsShort = 3;
   localparam int unsigned RsvBitsLong  = 5;
   localparam int unsigned SnBitsShort  = 12;
   localparam int unsigned SnBitsLong   = 18;
   localparam int unsigned DcBit        = HdrWidth - 1;
   localparam int unsigned SnLsbShort   = HdrWidth - 1 - RsvBitsShort - SnBitsShort;
   localparam int unsigned SnLsbLong    = HdrWidth - 1 - RsvBitsLong - SnBitsLong;

   // Header lengths in bytes.
   localparam logic [1:0] HdrLenShort = 2'd2;
   localparam logic [1:0] HdrLenLong  = 2'd3;

   // Result status codes.
   typedef enum logic [1:0] {
      StDataOk      = 2'd0,
      StCtrlIgnored = 2'd1,
      StEmptyPdu    = 2'd2,
      StBadSnLen    = 2'd3
   } status_type;

   // Sequence number length selection codes.
   localparam logic [CfgWidth-1:0] SnSel12 = 2'd0;
   localparam logic [CfgWidth-1:0] SnSel18 = 2'd1;

   // One result word.
   typedef struct packed {
      status_type             status;
      logic                   pdu_kind;
      logic [SnWidth-1:0]     received_sn;
      logic [CountWidth-1:0]  derived_count;
      logic [1:0]             header_length;
   } rsp_type;

   // State update that goes with one result word.
   typedef struct packed {
      logic                   update;
      logic [CountWidth-1:0]  next_count;
   } state_upd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/prcd_ifs.sv =====
// Valid/ready channel interfaces for PDU header words and result words.
`default_nettype none

interface pdcp_req_if;
   import prcd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [HdrWidth-1:0]  header_bytes;
   logic [LenWidth-1:0]  pdu_length;

   modport source (output valid, output header_bytes, output pdu_length, input ready);
   modport sink   (input valid, input header_bytes, input pdu_length, output ready);
endinterface

interface pdcp_rsp_if;
   import prcd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic                   pdu_kind;
   logic [SnWidth-1:0]     received_sn;
   logic [CountWidth-1:0]  derived_count;
   logic [1:0]             header_length;

   modport source (output valid, output status, output pdu_kind, output received_sn,
                   output derived_count, output header_length, input ready);
   modport sink   (input valid, input status, input pdu_kind, input received_sn,
                   input derived_count, input header_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prcd_in_stage.sv =====
// Input register that captures one header word per cycle while it is empty or its word moves on.
`default_nettype none

module prcd_in_stage
   import prcd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   pdcp_req_if.sink           req_chan,
   input  wire logic          advance,
   output logic               s1_valid,
   output logic [HdrWidth-1:0] s1_header,
   output logic [LenWidth-1:0] s1_length
);

   logic                valid_ff;
   logic                valid_in;
   logic [HdrWidth-1:0] header_ff;
   logic [LenWidth-1:0] length_ff;
   logic                take;

   // The stage takes a new word when empty or when its word moves on.
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         header_ff <= req_chan.header_bytes;
         length_ff <= req_chan.pdu_length;
      end
   end

   assign s1_valid  = valid_ff;
   assign s1_header = header_ff;
   assign s1_length = length_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/prcd_hfn_calc.sv =====
// Sequence number extraction, HFN choice and COUNT composition for one word.
`default_nettype none

module prcd_hfn_calc
   import prcd_pkg::*;
(
   input  wire logic [HdrWidth-1:0]   header,
   input  wire logic [LenWidth-1:0]   pdu_length,
   input  wire logic [CfgWidth-1:0]   sn_sel,
   input  wire logic [CountWidth-1:0] deliver_count,
   output rsp_type                    rsp,
   output state_upd_type              upd
);

   logic                  kind;
   logic                  sel_ok;
   logic [SnWidth-1:0]    sn;
   logic [SnWidth-1:0]    d_sn;
   logic [SnWidth:0]      win;
   logic [CountWidth-1:0] hfn_step;
   logic [CountWidth-1:0] hfn_base;
   logic [1:0]            hlen;
   logic                  below;
   logic                  above;
   logic [CountWidth-1:0] hfn_part;
   logic [CountWidth-1:0] count;

   assign kind = header[DcBit];

   // Field positions and window size for the selected SN length.
   always_comb begin
      sel_ok   = 1'b1;
      sn       = '0;
      d_sn     = '0;
      win      = '0;
      hfn_step = '0;
      hfn_base = '0;
      hlen     = '0;
      unique case (sn_sel)
         SnSel12: begin
            sn       = SnWidth'(header[SnLsbShort +: SnBitsShort]);
            d_sn     = SnWidth'(deliver_count[SnBitsShort-1:0]);
            win      = (SnWidth+1)'(1) << (SnBitsShort - 1);
            hfn_step = CountWidth'(1) << SnBitsShort;
            hfn_base = {deliver_count[CountWidth-1:SnBitsShort], SnBitsShort'(0)};
            hlen     = HdrLenShort;
         end
         SnSel18: begin
            sn       = SnWidth'(header[SnLsbLong +: SnBitsLong]);
            d_sn     = SnWidth'(deliver_count[SnBitsLong-1:0]);
            win      = (SnWidth+1)'(1) << (SnBitsLong - 1);
            hfn_step = CountWidth'(1) << SnBitsLong;
            hfn_base = {deliver_count[CountWidth-1:SnBitsLong], SnBitsLong'(0)};
            hlen     = HdrLenLong;
         end
         default: begin
            sel_ok = 1'b0;
         end
      endcase
   end

   // Half-window rule: far below the expected SN means the next HFN,
   // a half window or more above means the previous one.
   assign below = ({1'b0, sn} + win) < {1'b0, d_sn};
   assign above = {1'b0, sn} >= ({1'b0, d_sn} + win);

   always_comb begin
      if (below) begin
         hfn_part = hfn_base + hfn_step;
      end else if (above) begin
         hfn_part = hfn_base - hfn_step;
      end else begin
         hfn_part = hfn_base;
      end
   end

   assign count = hfn_part | CountWidth'(sn);

   // Result word; empty PDUs are checked before the D/C bit.
   always_comb begin
      rsp            = '0;
      upd.update     = 1'b0;
      upd.next_count = count + CountWidth'(1);
      if (pdu_length == '0) begin
         rsp.status = StEmptyPdu;
      end else if (!kind) begin
         rsp.status = StCtrlIgnored;
      end else if (!sel_ok) begin
         rsp.status   = StBadSnLen;
         rsp.pdu_kind = 1'b1;
      end else begin
         rsp.status        = StDataOk;
         rsp.pdu_kind      = 1'b1;
         rsp.received_sn   = sn;
         rsp.derived_count = count;
         rsp.header_length = hlen;
         upd.update        = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/prcd_out_stage.sv =====
// Result register and next-to-deliver COUNT register.
`default_nettype none

module prcd_out_stage
   import prcd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            s1_valid,
   input  wire rsp_type         rsp_next,
   input  wire state_upd_type   upd,
   output logic                 advance,
   output logic [CountWidth-1:0] deliver_count,
   pdcp_rsp_if.source           rsp_chan
);

   logic                  valid_ff;
   logic                  valid_in;
   rsp_type               rsp_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   // A word moves on when the result register is free or being emptied.
   assign advance = s1_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   // Stored COUNT follows each accepted data word in the same edge.
   always_comb begin
      count_in = count_ff;
      if (advance && upd.update) begin
         count_in = upd.next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign deliver_count          = count_ff;
   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.pdu_kind      = rsp_ff.pdu_kind;
   assign rsp_chan.received_sn   = rsp_ff.received_sn;
   assign rsp_chan.derived_count = rsp_ff.derived_count;
   assign rsp_chan.header_length = rsp_ff.header_length;

endmodule

`default_nettype wire

// ===== hw/rtl/pdcp_rx_count_derivation_unit.sv =====
// Each accepted word passes the input register and then the result register.
// Throughput: one word per cycle unless the result channel stalls; the COUNT loop
// through the HFN compare and add gives each word the COUNT left by the prior word.
// Reset (synchronous, active high) empties both registers, sets the stored COUNT
// to zero and the SN length selection to 12 bits.
`default_nettype none

module pdcp_rx_count_derivation_unit
   import prcd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   pdcp_req_if.sink                 req_chan,
   pdcp_rsp_if.source               rsp_chan,
   input  wire logic                csr_wr_en,
   input  wire logic [CfgWidth-1:0] csr_wr_data
);

   logic [CfgWidth-1:0]   sn_sel_ff;
   logic [CfgWidth-1:0]   sn_sel_in;
   logic                  s1_valid;
   logic [HdrWidth-1:0]   s1_header;
   logic [LenWidth-1:0]   s1_length;
   logic                  advance;
   logic [CountWidth-1:0] deliver_count;
   rsp_type               rsp_next;
   state_upd_type         upd;

   // SN length register.
   assign sn_sel_in = csr_wr_en ? csr_wr_data : sn_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sn_sel_ff <= SnSel12;
      end else begin
         sn_sel_ff <= sn_sel_in;
      end
   end

   prcd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_header (s1_header),
      .s1_length (s1_length)
   );

   prcd_hfn_calc u_hfn_calc (
      .header        (s1_header),
      .pdu_length    (s1_length),
      .sn_sel        (sn_sel_ff),
      .deliver_count (deliver_count),
      .rsp           (rsp_next),
      .upd           (upd)
   );

   prcd_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .s1_valid      (s1_valid),
      .rsp_next      (rsp_next),
      .upd           (upd),
      .advance       (advance),
      .deliver_count (deliver_count),
      .rsp_chan      (rsp_chan)
   );

endmodule

`default_nettype wire
